/* rtl/core/dtdl_pkg.sv */
// Package for the die temperature derate limiter: types, state encodings,
// register indexes and fixed constants. No dependencies.
`default_nettype none

package dtdl_pkg;

  localparam int ADDR_W      = 4;
  localparam int LANE_STEPS  = 17;
  localparam int MERGE_STEPS = 16;

  typedef logic signed [16:0] temp_t;

  localparam temp_t       TEMP_MIN    = 17'h10000;
  localparam temp_t       TEMP_MAX    = 17'h0FFFF;
  localparam temp_t       NO_DIE_TEMP = -17'sd960;
  localparam logic [16:0] FULL_DERATE = 17'h10000;

  localparam logic [15:0] RTH_RESET   = 16'd3277;
  localparam logic [26:0] LAG_RESET   = 27'd1000000;
  localparam temp_t       LIMIT_RESET = 17'sd2400;
  localparam logic [15:0] BAND_RESET  = 16'd160;

  typedef enum logic [1:0] {
    REG_RTH,
    REG_LAG,
    REG_LIMIT,
    REG_BAND
  } reg_idx_t;

  typedef enum logic [2:0] {
    L_IDLE,
    L_RISE,
    L_TARGET,
    L_DIFF,
    L_SCALE,
    L_DIV,
    L_APPLY
  } lane_state_t;

  typedef enum logic [2:0] {
    M_IDLE,
    M_HOT,
    M_PREP,
    M_DIV,
    M_FIN,
    M_HOLD
  } merge_state_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_LANES,
    T_MERGE
  } top_state_t;

  typedef struct packed {
    logic  busy;
    logic  known;
    temp_t temp;
  } lane_out_t;

  typedef struct packed {
    logic        hold;
    logic        tripped;
    logic [16:0] derate;
  } merge_out_t;

endpackage

`default_nettype wire

/* rtl/core/dtdl_if.sv */
// Handshake interfaces for the sample and result channels of the limiter.
// Plain valid/ready channels; no dependencies.
`default_nettype none

interface dtdl_sample_if;
  logic               valid;
  logic               ready;
  logic        [15:0] loss_a;
  logic signed [16:0] base_a;
  logic               valid_a;
  logic        [15:0] loss_b;
  logic signed [16:0] base_b;
  logic               valid_b;
  logic        [19:0] elapsed_us;

  modport source (
    output valid, loss_a, base_a, valid_a, loss_b, base_b, valid_b, elapsed_us,
    input  ready
  );
  modport sink (
    input  valid, loss_a, base_a, valid_a, loss_b, base_b, valid_b, elapsed_us,
    output ready
  );
endinterface

interface dtdl_result_if;
  logic               valid;
  logic               ready;
  logic        [16:0] derate;
  logic signed [16:0] junction_a;
  logic               known_a_out;
  logic signed [16:0] junction_b;
  logic               known_b_out;
  logic               tripped_out;

  modport source (
    output valid, derate, junction_a, known_a_out, junction_b, known_b_out, tripped_out,
    input  ready
  );
  modport sink (
    input  valid, derate, junction_a, known_a_out, junction_b, known_b_out, tripped_out,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/core/die_temperature_derate_limiter_unit.sv */
// Top level of the die temperature derate limiter: configuration registers,
// channel control and output register. Depends on dtdl_pkg, dtdl_if,
// dtdl_lane and dtdl_merge.
//
// Usage:
//   Each transfer on sample_ch is one tick carrying loss and base temperature
//   of two dies and the elapsed time. Each tick gives exactly one transfer on
//   result_ch with the derate, both junction estimates, known flags and the
//   trip state. Registers must be written over the APB port (byte address 4*i)
//   only while no tick is in flight; the block itself does not enforce this.
//   Timing: two die lanes run side by side, each with a 17-step divide of the
//   lag step; then the merge stage runs a 16-step divide of the derate ramp.
//   sample_ch is ready again in the cycle after the result is loaded into the
//   output register, so a new tick is only taken once the last one has reached
//   the output register.
//   Reset: synchronous rst clears the estimates, known flags, trip latch and
//   the output valid flag and restores the register defaults.
//   Stall: the finished result waits in the output register; the next tick is
//   taken and worked on meanwhile, and its result waits in the merge stage
//   until the output register is free.
`default_nettype none

module die_temperature_derate_limiter_unit (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [dtdl_pkg::ADDR_W-1:0]   paddr,
  input  wire [31:0]                   pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  dtdl_sample_if.sink                  sample_ch,
  dtdl_result_if.source                result_ch
);

  // configuration registers
  logic [15:0]       rth_q;
  logic [26:0]       lag_q;
  dtdl_pkg::temp_t   limit_q;
  logic [15:0]       band_q;
  dtdl_pkg::reg_idx_t reg_idx;
  logic              cfg_wr;

  dtdl_pkg::top_state_t state, state_next;

  dtdl_pkg::lane_out_t  lane_a_st, lane_b_st;
  dtdl_pkg::merge_out_t merge_st;

  logic accept;
  logic merge_start;
  logic take;

  // output register
  logic              out_valid_q;
  logic [16:0]       out_derate_q;
  dtdl_pkg::temp_t   out_ja_q;
  logic              out_ka_q;
  dtdl_pkg::temp_t   out_jb_q;
  logic              out_kb_q;
  logic              out_trip_q;

  assign reg_idx = dtdl_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rth_q   <= dtdl_pkg::RTH_RESET;
      lag_q   <= dtdl_pkg::LAG_RESET;
      limit_q <= dtdl_pkg::LIMIT_RESET;
      band_q  <= dtdl_pkg::BAND_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        dtdl_pkg::REG_RTH:   rth_q   <= pwdata[15:0];
        dtdl_pkg::REG_LAG:   lag_q   <= pwdata[26:0];
        dtdl_pkg::REG_LIMIT: limit_q <= pwdata[16:0];
        dtdl_pkg::REG_BAND:  band_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      dtdl_pkg::REG_RTH:   prdata = {16'b0, rth_q};
      dtdl_pkg::REG_LAG:   prdata = {5'b0, lag_q};
      dtdl_pkg::REG_LIMIT: prdata = {{15{limit_q[16]}}, limit_q};
      dtdl_pkg::REG_BAND:  prdata = {16'b0, band_q};
      default:             prdata = '0;
    endcase
  end

  // sequence: lanes, then merge, then hand over to the output register
  assign sample_ch.ready = (state == dtdl_pkg::T_IDLE);
  assign accept          = sample_ch.valid && sample_ch.ready;
  assign merge_start     = (state == dtdl_pkg::T_LANES) && !lane_a_st.busy && !lane_b_st.busy;
  assign take            = (state == dtdl_pkg::T_MERGE) && merge_st.hold
                           && (!out_valid_q || result_ch.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      dtdl_pkg::T_IDLE:  if (accept) state_next = dtdl_pkg::T_LANES;
      dtdl_pkg::T_LANES: if (merge_start) state_next = dtdl_pkg::T_MERGE;
      dtdl_pkg::T_MERGE: if (take) state_next = dtdl_pkg::T_IDLE;
      default:           state_next = dtdl_pkg::T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtdl_pkg::T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  dtdl_lane u_lane_a (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .loss   (sample_ch.loss_a),
    .base   (sample_ch.base_a),
    .valid  (sample_ch.valid_a),
    .dt     (sample_ch.elapsed_us),
    .rth    (rth_q),
    .lag    (lag_q),
    .status (lane_a_st)
  );

  dtdl_lane u_lane_b (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .loss   (sample_ch.loss_b),
    .base   (sample_ch.base_b),
    .valid  (sample_ch.valid_b),
    .dt     (sample_ch.elapsed_us),
    .rth    (rth_q),
    .lag    (lag_q),
    .status (lane_b_st)
  );

  dtdl_merge u_merge (
    .clk    (clk),
    .rst    (rst),
    .start  (merge_start),
    .take   (take),
    .lane_a (lane_a_st),
    .lane_b (lane_b_st),
    .limit  (limit_q),
    .band   (band_q),
    .result (merge_st)
  );

  // hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_derate_q <= merge_st.derate;
      out_ja_q     <= lane_a_st.temp;
      out_ka_q     <= lane_a_st.known;
      out_jb_q     <= lane_b_st.temp;
      out_kb_q     <= lane_b_st.known;
      out_trip_q   <= merge_st.tripped;
    end
  end

  assign result_ch.valid       = out_valid_q;
  assign result_ch.derate      = out_derate_q;
  assign result_ch.junction_a  = out_ja_q;
  assign result_ch.known_a_out = out_ka_q;
  assign result_ch.junction_b  = out_jb_q;
  assign result_ch.known_b_out = out_kb_q;
  assign result_ch.tripped_out = out_trip_q;

`ifndef SYNTHESIS
  a_accept_lanes_idle: assert property (@(posedge clk) disable iff (rst)
    accept |-> !lane_a_st.busy && !lane_b_st.busy)
    else $error("tick taken while a lane is busy");

  a_merge_lanes_idle: assert property (@(posedge clk) disable iff (rst)
    (state == dtdl_pkg::T_MERGE) |-> !lane_a_st.busy && !lane_b_st.busy)
    else $error("lane busy during merge");

  a_trip_full: assert property (@(posedge clk) disable iff (rst)
    (result_ch.valid && result_ch.tripped_out) |-> result_ch.derate == dtdl_pkg::FULL_DERATE)
    else $error("tripped result without full derate");

  a_trip_holds: assert property (@(posedge clk) disable iff (rst)
    merge_st.tripped |=> merge_st.tripped)
    else $error("trip latch cleared without reset");
`endif

endmodule

`default_nettype wire

/* rtl/core/dtdl_lane.sv */
// One die lane: junction estimate with a first-order lag, using its own
// restoring divider for the scaled step. Depends on dtdl_pkg.
`default_nettype none

module dtdl_lane (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  wire          [15:0] loss,
  input  dtdl_pkg::temp_t     base,
  input  wire                 valid,
  input  wire          [19:0] dt,
  input  wire          [15:0] rth,
  input  wire          [26:0] lag,
  output dtdl_pkg::lane_out_t status
);

  dtdl_pkg::lane_state_t state, state_next;

  logic        [15:0] loss_q;
  dtdl_pkg::temp_t    base_q;
  logic               valid_q;
  logic        [19:0] dt_q;
  logic        [31:0] prod_q;
  dtdl_pkg::temp_t    tgt_q;
  logic        [16:0] mag_q;
  logic               neg_q;
  logic        [26:0] rem_q;
  logic        [16:0] quo_q;
  logic        [4:0]  cnt_q;
  dtdl_pkg::temp_t    temp_q;
  logic               known_q;

  logic        [26:0] tau;
  logic        [32:0] rise_sum;
  logic        [20:0] rise;
  logic signed [21:0] tsum;
  dtdl_pkg::temp_t    tgt_sat;
  logic signed [17:0] diff;
  logic        [17:0] mag_w;
  logic        [36:0] mprod;
  logic        [37:0] num;
  logic        [27:0] trial;
  logic               geq;
  logic signed [17:0] t_apply;
  logic               dt_full;

  assign tau      = (lag == 27'd0) ? 27'd1 : lag;
  assign rise_sum = {1'b0, prod_q} + 33'd2048;
  assign rise     = rise_sum[32:12];
  assign tsum     = 22'(base_q) + $signed({1'b0, rise});

  always_comb begin
    if (tsum < -22'sd65536) begin
      tgt_sat = dtdl_pkg::TEMP_MIN;
    end else if (tsum > 22'sd65535) begin
      tgt_sat = dtdl_pkg::TEMP_MAX;
    end else begin
      tgt_sat = tsum[16:0];
    end
  end

  assign diff    = 18'(tgt_q) - 18'(temp_q);
  assign mag_w   = diff[17] ? 18'(-diff) : 18'(diff);
  assign dt_full = {7'b0, dt_q} >= tau;
  assign mprod   = 37'(mag_q) * 37'(dt_q);
  assign num     = {1'b0, mprod} + {12'b0, tau[26:1]};
  assign trial   = {rem_q, quo_q[16]};
  assign geq     = trial >= {1'b0, tau};
  assign t_apply = neg_q ? 18'(temp_q) - $signed({1'b0, quo_q})
                         : 18'(temp_q) + $signed({1'b0, quo_q});

  always_comb begin
    state_next = state;
    unique case (state)
      dtdl_pkg::L_IDLE:   if (start) state_next = dtdl_pkg::L_RISE;
      dtdl_pkg::L_RISE: begin
        if (!valid_q || !known_q) state_next = dtdl_pkg::L_IDLE;
        else state_next = dtdl_pkg::L_TARGET;
      end
      dtdl_pkg::L_TARGET: state_next = dtdl_pkg::L_DIFF;
      dtdl_pkg::L_DIFF: begin
        if (dt_full) state_next = dtdl_pkg::L_IDLE;
        else state_next = dtdl_pkg::L_SCALE;
      end
      dtdl_pkg::L_SCALE:  state_next = dtdl_pkg::L_DIV;
      dtdl_pkg::L_DIV: begin
        if (cnt_q == 5'(dtdl_pkg::LANE_STEPS - 1)) state_next = dtdl_pkg::L_APPLY;
      end
      dtdl_pkg::L_APPLY:  state_next = dtdl_pkg::L_IDLE;
      default:            state_next = dtdl_pkg::L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= dtdl_pkg::L_IDLE;
      temp_q  <= '0;
      known_q <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        dtdl_pkg::L_RISE: begin
          // first usable reading snaps to the base temperature
          if (valid_q && !known_q) begin
            temp_q  <= base_q;
            known_q <= 1'b1;
          end
        end
        dtdl_pkg::L_DIFF:  if (dt_full) temp_q <= tgt_q;
        dtdl_pkg::L_APPLY: temp_q <= t_apply[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == dtdl_pkg::L_IDLE && start) begin
      loss_q  <= loss;
      base_q  <= base;
      valid_q <= valid;
      dt_q    <= dt;
    end
    case (state)
      dtdl_pkg::L_RISE:   prod_q <= 32'(loss_q) * 32'(rth);
      dtdl_pkg::L_TARGET: tgt_q  <= tgt_sat;
      dtdl_pkg::L_DIFF: begin
        mag_q <= mag_w[16:0];
        neg_q <= diff[17];
      end
      dtdl_pkg::L_SCALE: begin
        rem_q <= 27'(num[37:17]);
        quo_q <= num[16:0];
        cnt_q <= '0;
      end
      dtdl_pkg::L_DIV: begin
        rem_q <= geq ? 27'(trial - {1'b0, tau}) : trial[26:0];
        quo_q <= {quo_q[15:0], geq};
        cnt_q <= cnt_q + 5'd1;
      end
      default: ;
    endcase
  end

  assign status.busy  = (state != dtdl_pkg::L_IDLE);
  assign status.known = known_q;
  assign status.temp  = temp_q;

endmodule

`default_nettype wire

/* rtl/core/dtdl_merge.sv */
// Merging stage: picks the hotter known die, computes the derate ramp with a
// restoring divider and holds the trip latch. Depends on dtdl_pkg.
`default_nettype none

module dtdl_merge (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  input  wire                  take,
  input  dtdl_pkg::lane_out_t  lane_a,
  input  dtdl_pkg::lane_out_t  lane_b,
  input  dtdl_pkg::temp_t      limit,
  input  wire           [15:0] band,
  output dtdl_pkg::merge_out_t result
);

  dtdl_pkg::merge_state_t state, state_next;

  dtdl_pkg::temp_t    hot_q;
  logic        [16:0] derate_q;
  logic        [15:0] rem_q;
  logic        [15:0] quo_q;
  logic        [3:0]  cnt_q;
  logic               trip_q;

  dtdl_pkg::temp_t    ta, tb, hot_w;
  logic signed [18:0] band_s;
  logic signed [18:0] n_w;
  logic               n_full;
  logic               n_zero;
  logic        [31:0] dvd;
  logic        [16:0] trial;
  logic               geq;

  assign ta = lane_a.known ? lane_a.temp : dtdl_pkg::NO_DIE_TEMP;
  assign tb = lane_b.known ? lane_b.temp : dtdl_pkg::NO_DIE_TEMP;

  always_comb begin
    hot_w = (ta > tb) ? ta : tb;
    if (hot_w < dtdl_pkg::NO_DIE_TEMP) hot_w = dtdl_pkg::NO_DIE_TEMP;
  end

  assign band_s = $signed({3'b0, band});
  assign n_w    = 19'(hot_q) - 19'(limit) + band_s;
  assign n_full = (n_w >= band_s);
  assign n_zero = (n_w <= 19'sd0);
  assign dvd    = {n_w[15:0], 16'b0} + {17'b0, band[15:1]};
  assign trial  = {rem_q, quo_q[15]};
  assign geq    = trial >= {1'b0, band};

  always_comb begin
    state_next = state;
    unique case (state)
      dtdl_pkg::M_IDLE: if (start) state_next = dtdl_pkg::M_HOT;
      dtdl_pkg::M_HOT:  state_next = dtdl_pkg::M_PREP;
      dtdl_pkg::M_PREP: begin
        if (n_full || n_zero) state_next = dtdl_pkg::M_HOLD;
        else state_next = dtdl_pkg::M_DIV;
      end
      dtdl_pkg::M_DIV: begin
        if (cnt_q == 4'(dtdl_pkg::MERGE_STEPS - 1)) state_next = dtdl_pkg::M_FIN;
      end
      dtdl_pkg::M_FIN:  state_next = dtdl_pkg::M_HOLD;
      dtdl_pkg::M_HOLD: if (take) state_next = dtdl_pkg::M_IDLE;
      default:          state_next = dtdl_pkg::M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= dtdl_pkg::M_IDLE;
      trip_q <= 1'b0;
    end else begin
      state <= state_next;
      if (state == dtdl_pkg::M_PREP && n_full) trip_q <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      dtdl_pkg::M_HOT: hot_q <= hot_w;
      dtdl_pkg::M_PREP: begin
        derate_q <= n_full ? dtdl_pkg::FULL_DERATE : 17'd0;
        rem_q    <= dvd[31:16];
        quo_q    <= dvd[15:0];
        cnt_q    <= '0;
      end
      dtdl_pkg::M_DIV: begin
        rem_q <= geq ? 16'(trial - {1'b0, band}) : trial[15:0];
        quo_q <= {quo_q[14:0], geq};
        cnt_q <= cnt_q + 4'd1;
      end
      dtdl_pkg::M_FIN: derate_q <= {1'b0, quo_q};
      default: ;
    endcase
  end

  assign result.hold    = (state == dtdl_pkg::M_HOLD);
  assign result.tripped = trip_q;
  assign result.derate  = trip_q ? dtdl_pkg::FULL_DERATE : derate_q;

endmodule

`default_nettype wire
